// ===== src/tisa_pkg.sv =====
// Shared types and constants of the toy ISA execute unit.
// Holds the instruction and result item structs, opcodes, error codes and
// register index constants. No dependencies.
package tisa_pkg;

  localparam int NUM_REGS = 20;
  localparam int REG_IDX_W = 5;
  localparam int DATA_W = 32;
  localparam int LINE_OUT_W = 10;

  localparam logic [3:0] OP_NOP = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_DIV = 4'd4;
  localparam logic [3:0] OP_LW  = 4'd5;
  localparam logic [3:0] OP_JMP = 4'd6;
  localparam logic [3:0] OP_BEQ = 4'd7;
  localparam logic [3:0] OP_BNE = 4'd8;
  localparam logic [3:0] OP_SLT = 4'd9;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_BAD_OP    = 3'd1;
  localparam logic [2:0] ERR_LW_DEST   = 3'd2;
  localparam logic [2:0] ERR_DIV_ZERO  = 3'd3;
  localparam logic [2:0] ERR_BAD_INDEX = 3'd4;

  localparam logic [4:0] IDX_S_FIRST = 5'd10;
  localparam logic [4:0] IDX_S_LAST  = 5'd17;
  localparam logic [4:0] IDX_V0      = 5'd18;
  localparam logic [4:0] IDX_ZERO    = 5'd19;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [4:0]        dst_reg;
    logic [4:0]        src_a_reg;
    logic [4:0]        src_b_reg;
    logic signed [31:0] imm_value;
  } instr_t;

  typedef struct packed {
    logic [9:0]         next_line;
    logic               branch_taken;
    logic               write_done;
    logic [4:0]         write_reg;
    logic signed [31:0] write_value;
    logic signed [31:0] v0_value;
    logic [2:0]         error_code;
  } result_t;

endpackage

// ===== src/tisa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the register file of the toy ISA execute unit. No dependencies.
module tisa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/toy_isa_execute_unit.sv =====
// Toy ISA execute unit: runs one decoded instruction per item on a 20-entry
// register file and a line counter. Depends on tisa_pkg and tisa_ram.
//
// Usage: one instruction is taken at a time. Add, sub, mul, slt, lw, nop,
// an untaken branch and any instruction with an error go from acceptance to
// result through two register-file reads on the single RAM read port, an
// execute step and a write-back step. Div, jmp and a taken branch also run
// the 32 iterations of the shared restoring divider, which also reduces
// the jump target minus one modulo PROGRAM_LINES. The next instruction
// is accepted as soon as the unit is back in idle, even while the previous
// result still waits in the output register; write-back stalls only if that
// register is still full. After reset the register file reads as zero at
// once; no clearing pass is needed.
module toy_isa_execute_unit #(
  parameter int PROGRAM_LINES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_ready,
  input  tisa_pkg::instr_t instr,
  output logic             result_valid,
  input  logic             result_ready,
  output tisa_pkg::result_t result
);

  localparam int LCW = $clog2(PROGRAM_LINES);
  localparam logic [LCW-1:0] LINE_LAST = LCW'(PROGRAM_LINES - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDB  = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                state;
  tisa_pkg::instr_t          cur;
  logic [2:0]                err_q;
  logic [31:0]               va;
  logic                      res_taken;
  logic                      res_wr;
  logic [31:0]               res_wval;
  logic [31:0]               div_rem;
  logic [31:0]               div_quo;
  logic [31:0]               div_dvs;
  logic                      div_neg;
  logic                      div_mod;
  logic [4:0]                cnt;
  logic [LCW-1:0]            lc;
  logic [31:0]               v0_reg;
  logic [tisa_pkg::NUM_REGS-1:0] valid_bits;

  logic                      ram_we;
  logic [4:0]                ram_raddr;
  logic [31:0]               ram_rdata;
  logic [31:0]               vb;
  logic [2:0]                err_in;
  logic                      accept;
  logic                      out_free;
  logic [32:0]               div_shift;
  logic [32:0]               div_diff;
  logic                      div_bit;
  logic [31:0]               div_rem_step;
  logic [31:0]               div_quo_step;
  logic [31:0]               q_signed;
  logic [LCW-1:0]            lc_next;
  logic [31:0]               alu_mul;
  logic [31:0]               abs_a;
  logic [31:0]               abs_b;
  logic                      take_br;
  logic                      use_div;

  function automatic logic reg_live(input logic [4:0] idx,
                                    input logic [tisa_pkg::NUM_REGS-1:0] vbits);
    reg_live = (idx < tisa_pkg::IDX_ZERO) ? vbits[idx] : 1'b0;
  endfunction

  assign instr_ready = (state == ST_IDLE);
  assign accept = instr_valid && instr_ready;
  assign out_free = !result_valid || result_ready;

  // Decode-time checks, in the order the error codes take priority
  always_comb begin
    logic is_alu;
    logic is_br;
    is_alu = ((instr.cmd >= tisa_pkg::OP_ADD) && (instr.cmd <= tisa_pkg::OP_DIV)) ||
             (instr.cmd == tisa_pkg::OP_SLT);
    is_br = (instr.cmd == tisa_pkg::OP_BEQ) || (instr.cmd == tisa_pkg::OP_BNE);
    priority if (instr.cmd > tisa_pkg::OP_SLT) begin
      err_in = tisa_pkg::ERR_BAD_OP;
    end else if (is_alu && ((instr.dst_reg > tisa_pkg::IDX_ZERO) ||
                            (instr.src_a_reg > tisa_pkg::IDX_ZERO) ||
                            (instr.src_b_reg > tisa_pkg::IDX_ZERO))) begin
      err_in = tisa_pkg::ERR_BAD_INDEX;
    end else if ((instr.cmd == tisa_pkg::OP_LW) &&
                 (instr.dst_reg > tisa_pkg::IDX_ZERO)) begin
      err_in = tisa_pkg::ERR_BAD_INDEX;
    end else if (is_br && ((instr.src_a_reg > tisa_pkg::IDX_ZERO) ||
                           (instr.src_b_reg > tisa_pkg::IDX_ZERO))) begin
      err_in = tisa_pkg::ERR_BAD_INDEX;
    end else if ((instr.cmd == tisa_pkg::OP_LW) &&
                 ((instr.dst_reg < tisa_pkg::IDX_S_FIRST) ||
                  (instr.dst_reg > tisa_pkg::IDX_S_LAST))) begin
      err_in = tisa_pkg::ERR_LW_DEST;
    end else begin
      err_in = tisa_pkg::ERR_OK;
    end
  end

  // Read port: a at acceptance, b in the next cycle (ST_RDB)
  always_comb begin
    if (state == ST_IDLE) begin
      ram_raddr = instr.src_a_reg;
    end else if (state == ST_RDB) begin
      ram_raddr = cur.src_b_reg;
    end else begin
      ram_raddr = cur.src_a_reg;
    end
  end

  assign vb = reg_live(cur.src_b_reg, valid_bits) ? ram_rdata : 32'd0;
  assign ram_we = (state == ST_DONE) && out_free && res_wr;

  tisa_ram #(
    .WIDTH (tisa_pkg::DATA_W),
    .DEPTH (tisa_pkg::NUM_REGS)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur.dst_reg),
    .wdata (res_wval),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Restoring divider step, shared by div and the target modulo
  assign div_shift = {div_rem, div_quo[31]};
  assign div_diff = div_shift - {1'b0, div_dvs};
  assign div_bit = !div_diff[32];
  assign div_rem_step = div_bit ? div_diff[31:0] : div_shift[31:0];
  assign div_quo_step = {div_quo[30:0], div_bit};
  assign q_signed = div_neg ? (32'd0 - div_quo_step) : div_quo_step;

  assign alu_mul = va * vb;
  assign abs_a = va[31] ? (32'd0 - va) : va;
  assign abs_b = vb[31] ? (32'd0 - vb) : vb;

  // Jump or taken branch, and whether execute hands over to the divider
  assign take_br = (cur.cmd == tisa_pkg::OP_JMP) ||
                   ((cur.cmd == tisa_pkg::OP_BEQ) && (va == vb)) ||
                   ((cur.cmd == tisa_pkg::OP_BNE) && (va != vb));
  assign use_div = (err_q == tisa_pkg::ERR_OK) &&
                   (((cur.cmd == tisa_pkg::OP_DIV) && (vb != 32'd0)) || take_br);

  assign lc_next = res_taken ? div_rem[LCW-1:0] :
                   ((lc == LINE_LAST) ? '0 : lc + LCW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lc <= '0;
      v0_reg <= '0;
      valid_bits <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur <= instr;
            err_q <= err_in;
            res_taken <= 1'b0;
            res_wr <= 1'b0;
            res_wval <= '0;
            state <= ST_RDB;
          end
        end
        ST_RDB: begin
          va <= reg_live(cur.src_a_reg, valid_bits) ? ram_rdata : 32'd0;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= use_div ? ST_DIV : ST_DONE;
          cnt <= '0;
          div_rem <= '0;
          if (err_q == tisa_pkg::ERR_OK) begin
            unique case (cur.cmd)
              tisa_pkg::OP_ADD: begin
                res_wr <= (cur.dst_reg != tisa_pkg::IDX_ZERO);
                res_wval <= va + vb;
              end
              tisa_pkg::OP_SUB: begin
                res_wr <= (cur.dst_reg != tisa_pkg::IDX_ZERO);
                res_wval <= va - vb;
              end
              tisa_pkg::OP_MUL: begin
                res_wr <= (cur.dst_reg != tisa_pkg::IDX_ZERO);
                res_wval <= alu_mul;
              end
              tisa_pkg::OP_SLT: begin
                res_wr <= (cur.dst_reg != tisa_pkg::IDX_ZERO);
                res_wval <= {31'd0, $signed(va) < $signed(vb)};
              end
              tisa_pkg::OP_LW: begin
                res_wr <= 1'b1;
                res_wval <= cur.imm_value;
              end
              tisa_pkg::OP_DIV: begin
                if (vb == 32'd0) begin
                  err_q <= tisa_pkg::ERR_DIV_ZERO;
                end else begin
                  div_quo <= abs_a;
                  div_dvs <= abs_b;
                  div_neg <= va[31] ^ vb[31];
                  div_mod <= 1'b0;
                end
              end
              tisa_pkg::OP_JMP, tisa_pkg::OP_BEQ, tisa_pkg::OP_BNE: begin
                if (take_br) begin
                  // reduce target minus one modulo the program length
                  res_taken <= 1'b1;
                  div_quo <= cur.imm_value - 32'd1;
                  div_dvs <= 32'(PROGRAM_LINES);
                  div_neg <= 1'b0;
                  div_mod <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          div_rem <= div_rem_step;
          div_quo <= div_quo_step;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            if (!div_mod) begin
              res_wr <= (cur.dst_reg != tisa_pkg::IDX_ZERO);
              res_wval <= q_signed;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            result.next_line <= tisa_pkg::LINE_OUT_W'(lc_next);
            result.branch_taken <= res_taken;
            result.write_done <= res_wr;
            result.write_reg <= res_wr ? cur.dst_reg : 5'd0;
            result.write_value <= res_wr ? res_wval : 32'd0;
            result.v0_value <= (res_wr && (cur.dst_reg == tisa_pkg::IDX_V0)) ?
                               res_wval : v0_reg;
            result.error_code <= err_q;
            lc <= lc_next;
            if (res_wr) begin
              valid_bits[cur.dst_reg] <= 1'b1;
              if (cur.dst_reg == tisa_pkg::IDX_V0) begin
                v0_reg <= res_wval;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_write_no_err: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.write_done) |-> (result.error_code == tisa_pkg::ERR_OK))
    else $error("register write reported together with an error");

  a_branch_no_err: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.branch_taken) |-> (result.error_code == tisa_pkg::ERR_OK))
    else $error("branch taken together with an error");

  a_no_zero_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (cur.dst_reg < tisa_pkg::IDX_ZERO))
    else $error("write to zero register or out-of-range index");

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RDB))
    else $error("accepted item did not start the read sequence");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV) && (cnt != 5'd31)) |=> ((state == ST_DIV) &&
                                               (cnt == $past(cnt) + 5'd1)))
    else $error("divider iteration count slipped");
`endif

endmodule

// ===== verif/toy_isa_execute_unit_test.sv =====
// Self-checking testbench for toy_isa_execute_unit: drives decoded instructions,
// predicts every result item and compares it field by field with the block.
// Depends on tisa_pkg and the execute unit RTL.
module toy_isa_execute_unit_test;

  localparam int unsigned PROGRAM_LINES = 1024;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // Opcodes past the last legal one
  localparam logic [3:0] OP_FIRST_BAD = 4'd10;
  localparam logic [3:0] OP_LAST_BAD  = 4'd15;

  // Register names used by the directed items
  localparam logic [4:0] REG_T0 = 5'd0;
  localparam logic [4:0] REG_T1 = 5'd1;
  localparam logic [4:0] REG_T2 = 5'd2;
  localparam logic [4:0] REG_T3 = 5'd3;
  localparam logic [4:0] REG_T4 = 5'd4;
  localparam logic [4:0] REG_T5 = 5'd5;
  localparam logic [4:0] REG_T6 = 5'd6;
  localparam logic [4:0] REG_T9 = 5'd9;
  localparam logic [4:0] REG_S0 = tisa_pkg::IDX_S_FIRST;
  localparam logic [4:0] REG_S1 = tisa_pkg::IDX_S_FIRST + 5'd1;
  localparam logic [4:0] REG_S2 = tisa_pkg::IDX_S_FIRST + 5'd2;
  localparam logic [4:0] REG_S3 = tisa_pkg::IDX_S_FIRST + 5'd3;
  localparam logic [4:0] REG_FIRST_BAD = tisa_pkg::IDX_ZERO + 5'd1;
  localparam logic [4:0] REG_LAST_BAD  = 5'd31;

  class isa_result_checker;
    logic [31:0]         regs [tisa_pkg::NUM_REGS];
    int unsigned         cur_line;
    tisa_pkg::result_t   expected_results [$];
    int                  n_issued;
    int                  n_checked;
    int                  n_errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      cur_line  = 0;
      n_issued  = 0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function logic [31:0] read_reg(logic [4:0] idx);
      return (idx >= tisa_pkg::IDX_ZERO) ? 32'd0 : regs[idx];
    endfunction

    function tisa_pkg::result_t execute_instr(tisa_pkg::instr_t ins);
      tisa_pkg::result_t r;
      logic [31:0] va, vb, wval, ma, mb, q, tgt;
      logic [2:0]  err;
      logic        wr, taken;
      r     = '0;
      err   = tisa_pkg::ERR_OK;
      wr    = 1'b0;
      taken = 1'b0;
      wval  = '0;
      if (ins.cmd > tisa_pkg::OP_SLT) begin
        err = tisa_pkg::ERR_BAD_OP;
      end else if (((ins.cmd >= tisa_pkg::OP_ADD && ins.cmd <= tisa_pkg::OP_DIV) ||
                    ins.cmd == tisa_pkg::OP_SLT) &&
                   (ins.dst_reg > tisa_pkg::IDX_ZERO ||
                    ins.src_a_reg > tisa_pkg::IDX_ZERO ||
                    ins.src_b_reg > tisa_pkg::IDX_ZERO)) begin
        err = tisa_pkg::ERR_BAD_INDEX;
      end else if (ins.cmd == tisa_pkg::OP_LW && ins.dst_reg > tisa_pkg::IDX_ZERO) begin
        err = tisa_pkg::ERR_BAD_INDEX;
      end else if ((ins.cmd == tisa_pkg::OP_BEQ || ins.cmd == tisa_pkg::OP_BNE) &&
                   (ins.src_a_reg > tisa_pkg::IDX_ZERO ||
                    ins.src_b_reg > tisa_pkg::IDX_ZERO)) begin
        err = tisa_pkg::ERR_BAD_INDEX;
      end else if (ins.cmd == tisa_pkg::OP_LW &&
                   (ins.dst_reg < tisa_pkg::IDX_S_FIRST ||
                    ins.dst_reg > tisa_pkg::IDX_S_LAST)) begin
        err = tisa_pkg::ERR_LW_DEST;
      end

      if (err == tisa_pkg::ERR_OK) begin
        va = read_reg(ins.src_a_reg);
        vb = read_reg(ins.src_b_reg);
        case (ins.cmd)
          tisa_pkg::OP_ADD: begin
            wr = 1'b1;
            wval = va + vb;
          end
          tisa_pkg::OP_SUB: begin
            wr = 1'b1;
            wval = va - vb;
          end
          tisa_pkg::OP_MUL: begin
            wr = 1'b1;
            wval = va * vb;
          end
          tisa_pkg::OP_DIV: begin
            if (vb == 0) begin
              err = tisa_pkg::ERR_DIV_ZERO;
            end else begin
              // divide magnitudes, then restore the sign; truncates toward zero
              ma = va[31] ? -va : va;
              mb = vb[31] ? -vb : vb;
              q  = ma / mb;
              wr = 1'b1;
              wval = (va[31] ^ vb[31]) ? -q : q;
            end
          end
          tisa_pkg::OP_LW: begin
            wr = 1'b1;
            wval = ins.imm_value;
          end
          tisa_pkg::OP_JMP: taken = 1'b1;
          tisa_pkg::OP_BEQ: taken = (va == vb);
          tisa_pkg::OP_BNE: taken = (va != vb);
          tisa_pkg::OP_SLT: begin
            wr = 1'b1;
            wval = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
          end
          default: ;
        endcase
      end

      // drop writes to the zero register silently
      if (wr && ins.dst_reg >= tisa_pkg::IDX_ZERO) wr = 1'b0;
      if (wr) regs[ins.dst_reg] = wval;
      else wval = '0;

      if (taken) begin
        tgt = ins.imm_value;
        tgt = tgt - 32'd1;
        cur_line = tgt % PROGRAM_LINES;
      end else begin
        cur_line = (cur_line + 1) % PROGRAM_LINES;
      end

      r.next_line    = cur_line[9:0];
      r.branch_taken = taken;
      r.write_done   = wr;
      r.write_reg    = wr ? ins.dst_reg : 5'd0;
      r.write_value  = wval;
      r.v0_value     = read_reg(tisa_pkg::IDX_V0);
      r.error_code   = err;
      return r;
    endfunction

    function void note_instr(tisa_pkg::instr_t ins);
      expected_results.push_back(execute_instr(ins));
      n_issued++;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void check_result(tisa_pkg::result_t got);
      tisa_pkg::result_t exp;
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("Mismatch %0d: result item with nothing outstanding, line=%0d err=%0d",
                   n_errors, got.next_line, got.error_code);
        return;
      end
      exp = expected_results.pop_front();
      n_checked++;
      if (got.next_line !== exp.next_line || got.branch_taken !== exp.branch_taken ||
          got.write_done !== exp.write_done || got.write_reg !== exp.write_reg ||
          got.write_value !== exp.write_value || got.v0_value !== exp.v0_value ||
          got.error_code !== exp.error_code) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("Mismatch %0d on result %0d: exp line=%0d br=%0b wr=%0b reg=%0d val=%0d v0=%0d err=%0d",
                   n_errors, n_checked, exp.next_line, exp.branch_taken, exp.write_done,
                   exp.write_reg, exp.write_value, exp.v0_value, exp.error_code);
          $display("    got line=%0d br=%0b wr=%0b reg=%0d val=%0d v0=%0d err=%0d",
                   got.next_line, got.branch_taken, got.write_done, got.write_reg,
                   got.write_value, got.v0_value, got.error_code);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              instr_valid = 1'b0;
  logic              instr_ready;
  tisa_pkg::instr_t  instr = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  tisa_pkg::result_t result;

  isa_result_checker checker_h;
  int   sender_idle_pct = 22;
  int   recv_idle_pct = 72;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  toy_isa_execute_unit #(
    .PROGRAM_LINES(PROGRAM_LINES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .instr_valid(instr_valid),
    .instr_ready(instr_ready),
    .instr(instr),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check accepted items, stall at random, and hold off on request
  always @(posedge clk) begin
    if (result_valid && result_ready) checker_h.check_result(result);
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic tisa_pkg::instr_t make_instr(input logic [3:0] op,
                                                  input logic [4:0] d,
                                                  input logic [4:0] a,
                                                  input logic [4:0] b,
                                                  input logic [31:0] imm);
    tisa_pkg::instr_t ins;
    ins.cmd       = op;
    ins.dst_reg   = d;
    ins.src_a_reg = a;
    ins.src_b_reg = b;
    ins.imm_value = imm;
    return ins;
  endfunction

  function automatic logic [4:0] rand_reg();
    if ($urandom_range(99) < 3) return 5'($urandom_range(REG_LAST_BAD, REG_FIRST_BAD));
    return 5'($urandom_range(tisa_pkg::IDX_ZERO, 0));
  endfunction

  function automatic tisa_pkg::instr_t rand_instr();
    tisa_pkg::instr_t ins;
    if ($urandom_range(99) < 4) ins.cmd = 4'($urandom_range(OP_LAST_BAD, OP_FIRST_BAD));
    else ins.cmd = 4'($urandom_range(tisa_pkg::OP_SLT, tisa_pkg::OP_NOP));
    ins.dst_reg   = rand_reg();
    ins.src_a_reg = rand_reg();
    ins.src_b_reg = rand_reg();
    // steer most loads into the s registers so that operands vary
    if (ins.cmd == tisa_pkg::OP_LW && $urandom_range(3) != 0)
      ins.dst_reg = 5'($urandom_range(tisa_pkg::IDX_S_LAST, tisa_pkg::IDX_S_FIRST));
    if ((ins.cmd == tisa_pkg::OP_BEQ || ins.cmd == tisa_pkg::OP_BNE) &&
        $urandom_range(2) == 0)
      ins.src_b_reg = ins.src_a_reg;
    case ($urandom_range(7))
      0, 1: ins.imm_value = $urandom_range(PROGRAM_LINES + 1, 0);
      2: begin
        case ($urandom_range(3))
          0: ins.imm_value = 32'h7FFF_FFFF;
          1: ins.imm_value = 32'h8000_0000;
          2: ins.imm_value = '1;
          default: ins.imm_value = '0;
        endcase
      end
      3: ins.imm_value = $urandom_range(16) - 8;
      default: ins.imm_value = $urandom;
    endcase
    return ins;
  endfunction

  // Offer one item, idling first at random; valid stays high into the next call
  task automatic send_instr(input tisa_pkg::instr_t ins);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      instr_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    instr_valid <= 1'b1;
    instr <= ins;
    @(posedge clk);
    while (!instr_ready) @(posedge clk);
    checker_h.note_instr(ins);
  endtask

  task automatic wait_drained();
    instr_valid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) send_instr(rand_instr());
  endtask

  initial begin
    tisa_pkg::instr_t directed_set [$];
    checker_h = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    directed_set.push_back(make_instr(tisa_pkg::OP_LW, REG_S0, REG_T0, REG_T0,
                                      32'h7FFF_FFFF));
    directed_set.push_back(make_instr(tisa_pkg::OP_LW, REG_S1, REG_T0, REG_T0,
                                      32'h8000_0000));
    directed_set.push_back(make_instr(tisa_pkg::OP_LW, REG_S2, REG_T0, REG_T0,
                                      32'hFFFF_FFFF));
    directed_set.push_back(make_instr(tisa_pkg::OP_LW, REG_S3, REG_T0, REG_T0, -32'sd7));
    directed_set.push_back(make_instr(tisa_pkg::OP_ADD, tisa_pkg::IDX_V0, REG_S0, REG_S2,
                                      '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_ADD, REG_T0, REG_S0, REG_S0, '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_SUB, REG_T1, REG_S1, REG_S0, '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_MUL, REG_T2, REG_S0, REG_S0, '0));
    // most negative value divided by minus one
    directed_set.push_back(make_instr(tisa_pkg::OP_DIV, REG_T3, REG_S1, REG_S2, '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_DIV, REG_T4, REG_S3, REG_T0, '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_DIV, REG_T5, REG_S0, tisa_pkg::IDX_ZERO,
                                      '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_DIV, REG_T5, REG_S0, REG_T9, '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_SLT, REG_T6, REG_S1, REG_S0, '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_ADD, tisa_pkg::IDX_ZERO, REG_S0, REG_S0,
                                      '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_LW, REG_T0, REG_T0, REG_T0, 32'd5));
    directed_set.push_back(make_instr(tisa_pkg::OP_LW, tisa_pkg::IDX_ZERO, REG_T0, REG_T0,
                                      32'd123));
    directed_set.push_back(make_instr(tisa_pkg::OP_LW, REG_LAST_BAD, REG_T0, REG_T0,
                                      32'd1));
    directed_set.push_back(make_instr(OP_FIRST_BAD, REG_T0, REG_T0, REG_T0, '0));
    directed_set.push_back(make_instr(OP_LAST_BAD, REG_LAST_BAD, REG_LAST_BAD,
                                      REG_LAST_BAD, '1));
    directed_set.push_back(make_instr(tisa_pkg::OP_SUB, REG_FIRST_BAD, REG_S0, REG_S1,
                                      '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_BEQ, REG_T0, REG_S0, REG_LAST_BAD,
                                      32'd4));
    // target zero wraps onto the last line
    directed_set.push_back(make_instr(tisa_pkg::OP_JMP, REG_T0, REG_T0, REG_T0, '0));
    directed_set.push_back(make_instr(tisa_pkg::OP_BEQ, REG_T0, REG_S0, REG_S0, 32'd1));
    directed_set.push_back(make_instr(tisa_pkg::OP_BNE, REG_T0, REG_S0, REG_S0, 32'd5));
    directed_set.push_back(make_instr(tisa_pkg::OP_BNE, REG_T0, REG_S0, REG_S1,
                                      32'h7FFF_FFFF));
    directed_set.push_back(make_instr(tisa_pkg::OP_NOP, REG_LAST_BAD, REG_LAST_BAD,
                                      REG_LAST_BAD, 32'h8000_0000));

    foreach (directed_set[i]) send_instr(directed_set[i]);
    send_random(300);
    wait_drained();

    sender_idle_pct = 72;
    recv_idle_pct = 22;
    send_random(300);
    wait_drained();

    // no idling; hold the result side off so that the unit backs up
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    hold_toggle <= ~hold_toggle;
    send_random(324);
    wait_drained();
    repeat (60) @(posedge clk);

    $display("Executed %0d instructions and checked %0d results over three idling phases",
             checker_h.n_issued, checker_h.n_checked);
    $display("plus a %0d-cycle result stall; %0d mismatches seen.",
             HOLD_CYCLES, checker_h.n_errors);
    if (checker_h.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout: run did not complete");
    $display("Verification failed");
    $finish;
  end

endmodule
